FILE: sv/fnvh_pkg.sv
// Package for the FNV-1a interning table: constants and sequencer states.
// No dependencies.
package fnvh_pkg;
    localparam int KEY_WORDS = 8;
    localparam int DEF_CAPACITY = 512;
    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
    localparam logic [8:0] FILL_RESET = 9'd256;
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_CMP,
        ST_CLEAR,
        ST_INIT
    } t_state;
endpackage

FILE: sv/fnvh_hash.sv
// Byte-serial FNV-1a unit: one byte folded per cycle, 64 bytes a key.
// Depends on fnvh_pkg.
module fnvh_hash import fnvh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [511:0] i_key,
    output logic        o_done,
    output logic [63:0] o_hash
);
    logic [63:0] r_h, n_h;
    logic [63:0] w_x;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic [7:0]  w_byte;

    // select the current byte, low byte of word 0 first
    assign w_byte = i_key[{r_cnt, 3'b000} +: 8];
    // one xor-multiply step; shift-add by the sparse prime 2^40+2^8+0xB3
    always_comb begin
        w_x = r_h ^ {56'd0, w_byte};
        n_h = (w_x << 40) + (w_x << 8) + (w_x << 7) + (w_x << 5) + (w_x << 4) +
              (w_x << 1) + w_x;
    end

    // advance the hash one byte per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_h <= FNV_BASIS;
            end else if (r_run) begin
                r_h <= n_h;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_run <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_hash = r_h;
endmodule

FILE: sv/fnv_hash_dedup_table.sv
// Top level of the FNV-1a interning table: sequencer, key memory, valid memory.
// Depends on fnvh_pkg and fnvh_hash.
//
// A lookup keeps busy high during byte-serial hashing in the FNV unit, then
// for the probes; each probe reads the slot's key row and valid bit from
// memory, then compares and decides. The result strobe o_done rises in the
// same cycle that busy drops. A clear keeps busy high while the valid bits of
// all CAPACITY slots are wiped one slot per cycle, then reports. After reset
// busy is high for the same wipe. Results cannot be held off; a new request
// may be accepted in the result cycle.
module fnv_hash_dedup_table import fnvh_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_operation,
    input  logic [63:0] i_key_word_0,
    input  logic [63:0] i_key_word_1,
    input  logic [63:0] i_key_word_2,
    input  logic [63:0] i_key_word_3,
    input  logic [63:0] i_key_word_4,
    input  logic [63:0] i_key_word_5,
    input  logic [63:0] i_key_word_6,
    input  logic [63:0] i_key_word_7,
    output logic        o_done,
    output logic [8:0]  o_slot_index,
    output logic        o_hit,
    output logic        o_inserted,
    output logic        o_table_full
);
    localparam int AW = $clog2(CAPACITY);
    localparam int OW = AW + 1;
    localparam int CW = (OW > 9) ? OW : 9;

    t_state r_state, n_state;
    logic [511:0] r_key;
    logic [8:0]   r_fill;
    logic [OW-1:0] r_occ;
    logic [AW-1:0] r_slot;
    logic [OW-1:0] r_i;
    logic [511:0] r_rd;
    logic         r_vrd;
    logic [511:0] mem [CAPACITY];
    logic         vmem [CAPACITY];
    logic hash_done;
    logic [63:0] hash;
    logic hash_go;
    logic w_full;
    logic w_match;
    logic w_last;
    logic w_wipe_end;
    logic w_kwe;
    logic w_vwe;
    logic w_vdat;

    fnvh_hash u_hash (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(hash_go),
        .i_key(r_key), .o_done(hash_done), .o_hash(hash));

    assign busy = (r_state != ST_IDLE);
    assign w_full = (CW'(r_occ) >= CW'(r_fill)) || (CW'(r_occ) >= CW'(CAPACITY));
    assign w_match = (r_rd == r_key);
    assign w_last = (r_i == OW'(CAPACITY - 1));
    assign w_wipe_end = (r_slot == AW'(CAPACITY - 1));
    // store on a miss with room; wipe valid bits during clear and after reset
    assign w_kwe = (r_state == ST_CMP) && !r_vrd && !w_full;
    assign w_vwe = w_kwe || (r_state == ST_CLEAR) || (r_state == ST_INIT);
    assign w_vdat = (r_state == ST_CMP);

    // key and valid memories: registered read of the probed slot
    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_slot];
        r_vrd <= vmem[r_slot];
        if (w_kwe) mem[r_slot] <= r_key;
        if (w_vwe) vmem[r_slot] <= w_vdat;
    end

    always_comb begin
        n_state = r_state;
        hash_go = 1'b0;
        unique case (r_state)
            ST_IDLE: if (start) begin
                n_state = (i_operation == OP_CLEAR) ? ST_CLEAR : ST_HASH;
                hash_go = (i_operation == OP_LOOKUP);
            end
            ST_HASH: if (hash_done) n_state = ST_PROBE;
            ST_PROBE: n_state = ST_CMP;
            ST_CMP: n_state = (!r_vrd || w_match || w_last) ? ST_IDLE : ST_PROBE;
            ST_CLEAR: if (w_wipe_end) n_state = ST_IDLE;
            ST_INIT: if (w_wipe_end) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequence requests, probe and report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_fill <= FILL_RESET;
            r_occ <= '0;
            r_slot <= '0;
            r_i <= '0;
            o_done <= 1'b0;
            o_hit <= 1'b0;
            o_inserted <= 1'b0;
            o_table_full <= 1'b0;
            o_slot_index <= 9'd0;
        end else begin
            r_state <= n_state;
            o_done <= 1'b0;
            if (i_cfg_we) r_fill <= i_cfg_data;
            unique case (r_state)
                ST_IDLE: if (start) begin
                    r_key <= {i_key_word_7, i_key_word_6, i_key_word_5, i_key_word_4,
                              i_key_word_3, i_key_word_2, i_key_word_1, i_key_word_0};
                    r_slot <= '0;
                end
                ST_HASH: begin
                    r_slot <= hash[AW-1:0];
                    r_i <= '0;
                end
                ST_PROBE: ;
                ST_CMP: begin
                    if (!r_vrd) begin
                        o_done <= 1'b1;
                        o_hit <= 1'b0;
                        o_inserted <= !w_full;
                        o_table_full <= w_full;
                        o_slot_index <= w_full ? 9'd0 : 9'(r_slot);
                        if (!w_full) r_occ <= r_occ + 1'b1;
                    end else if (w_match) begin
                        o_done <= 1'b1;
                        o_hit <= 1'b1;
                        o_inserted <= 1'b0;
                        o_table_full <= 1'b0;
                        o_slot_index <= 9'(r_slot);
                    end else if (w_last) begin
                        o_done <= 1'b1;
                        o_hit <= 1'b0;
                        o_inserted <= 1'b0;
                        o_table_full <= 1'b1;
                        o_slot_index <= 9'd0;
                    end else begin
                        r_slot <= r_slot + AW'(r_i + 1'b1);
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_CLEAR: begin
                    r_slot <= r_slot + 1'b1;
                    r_occ <= '0;
                    if (w_wipe_end) begin
                        o_done <= 1'b1;
                        o_hit <= 1'b0;
                        o_inserted <= 1'b0;
                        o_table_full <= 1'b0;
                        o_slot_index <= 9'd0;
                    end
                end
                ST_INIT: r_slot <= r_slot + 1'b1;
                default: ;
            endcase
        end
    end
endmodule

FILE: sim/tb_top.sv
// Testbench for the FNV-1a interning table: directed and random lookups and
// clears, checked against an in-bench table model. Depends on fnvh_pkg and
// fnv_hash_dedup_table.
`timescale 1ns / 100ps

class dedup_scoreboard;
    typedef struct {
        logic [8:0] slot_index;
        logic       hit;
        logic       inserted;
        logic       table_full;
    } t_outcome;

    logic [63:0] key_store [512][8];
    bit          slot_used [512];
    int unsigned occupancy;
    int unsigned fill_limit;
    t_outcome    pending [$];
    int          errors;

    function new();
        foreach (slot_used[s]) slot_used[s] = 0;
        occupancy = 0;
        fill_limit = fnvh_pkg::FILL_RESET;
        errors = 0;
    endfunction

    function logic [63:0] fnv_of(logic [63:0] key [8]);
        logic [63:0] h;
        h = fnvh_pkg::FNV_BASIS;
        for (int w = 0; w < 8; w++)
            for (int b = 0; b < 8; b++) begin
                h = h ^ {56'd0, key[w][8*b +: 8]};
                h = h * fnvh_pkg::FNV_PRIME;
            end
        return h;
    endfunction

    // Predict the result of one accepted request and update the table.
    function void note_request(logic op, logic [63:0] key [8]);
        t_outcome r;
        logic [63:0] h;
        logic [8:0] off;
        bit found_empty;
        bit same;
        r = '{default: 0};
        if (op == fnvh_pkg::OP_CLEAR) begin
            foreach (slot_used[s]) slot_used[s] = 0;
            occupancy = 0;
            pending.push_back(r);
            return;
        end
        h = fnv_of(key);
        off = h[8:0];
        found_empty = 0;
        for (int i = 0; i < 512; i++) begin
            off = off + i[8:0];
            if (!slot_used[off]) begin
                found_empty = 1;
                break;
            end
            same = 1;
            for (int w = 0; w < 8; w++)
                if (key_store[off][w] !== key[w]) same = 0;
            if (same) begin
                r.slot_index = off;
                r.hit = 1;
                pending.push_back(r);
                return;
            end
        end
        if (!found_empty || occupancy >= fill_limit || occupancy >= 512) begin
            r.table_full = 1;
        end else begin
            for (int w = 0; w < 8; w++) key_store[off][w] = key[w];
            slot_used[off] = 1;
            occupancy++;
            r.slot_index = off;
            r.inserted = 1;
        end
        pending.push_back(r);
    endfunction

    // Compare one result with the oldest prediction.
    function void check_result(logic [8:0] slot, logic hit, logic ins, logic full);
        t_outcome e;
        if (pending.size() == 0) begin
            $error("result with no request pending");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (slot !== e.slot_index) begin
            $error("slot_index expected %0d actual %0d", e.slot_index, slot);
            errors++;
        end
        if (hit !== e.hit) begin
            $error("hit expected %0d actual %0d", e.hit, hit);
            errors++;
        end
        if (ins !== e.inserted) begin
            $error("inserted expected %0d actual %0d", e.inserted, ins);
            errors++;
        end
        if (full !== e.table_full) begin
            $error("table_full expected %0d actual %0d", e.table_full, full);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import fnvh_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [8:0]  i_cfg_data;
    logic        i_operation;
    logic [63:0] key_w [8];
    logic        o_done;
    logic [8:0]  o_slot_index;
    logic        o_hit;
    logic        o_inserted;
    logic        o_table_full;

    dedup_scoreboard table_model;
    logic [63:0] key_pool [16][8];
    int unsigned cycle_count;
    bit          idle_allowed;
    logic [8:0]  int_limits [4] = '{9'd0, 9'd8, 9'd256, 9'd300};

    fnv_hash_dedup_table u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_operation  (i_operation),
        .i_key_word_0 (key_w[0]),
        .i_key_word_1 (key_w[1]),
        .i_key_word_2 (key_w[2]),
        .i_key_word_3 (key_w[3]),
        .i_key_word_4 (key_w[4]),
        .i_key_word_5 (key_w[5]),
        .i_key_word_6 (key_w[6]),
        .i_key_word_7 (key_w[7]),
        .o_done       (o_done),
        .o_slot_index (o_slot_index),
        .o_hit        (o_hit),
        .o_inserted   (o_inserted),
        .o_table_full (o_table_full)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Check every result and stop on a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done)
            table_model.check_result(o_slot_index, o_hit, o_inserted, o_table_full);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    // Hold until the block is idle, then send one request for one cycle.
    task automatic send_request(logic op, logic [63:0] key [8]);
        if (idle_allowed && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        i_operation <= op;
        for (int w = 0; w < 8; w++) key_w[w] <= key[w];
        start <= 1'b1;
        @(posedge i_clk);
        table_model.note_request(op, key);
        @(negedge i_clk);
        start <= 1'b0;
        i_operation <= 1'($urandom_range(0, 1));
    endtask

    task automatic send_key_from_pool(int idx);
        logic [63:0] k [8];
        for (int w = 0; w < 8; w++) k[w] = key_pool[idx][w];
        send_request(OP_LOOKUP, k);
    endtask

    task automatic send_random_key();
        logic [63:0] k [8];
        for (int w = 0; w < 8; w++) k[w] = rand_word();
        send_request(OP_LOOKUP, k);
    endtask

    task automatic send_clear();
        logic [63:0] k [8];
        for (int w = 0; w < 8; w++) k[w] = rand_word();
        send_request(OP_CLEAR, k);
    endtask

    // Write fill_limit once all results are in and the block is quiet.
    task automatic write_fill_limit(logic [8:0] value);
        while (table_model.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_data <= value;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        table_model.fill_limit = value;
    endtask

    initial begin
        logic [63:0] k [8];
        int unsigned wait_cycles;
        table_model = new();
        cycle_count = 0;
        idle_allowed = 0;
        start = 0;
        i_cfg_we = 0;
        i_cfg_data = '0;
        i_operation = OP_LOOKUP;
        for (int w = 0; w < 8; w++) key_w[w] = '0;
        for (int p = 0; p < 16; p++)
            for (int w = 0; w < 8; w++) key_pool[p][w] = rand_word();
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extreme keys, repeat hits, clear, full at small limit.
        for (int w = 0; w < 8; w++) k[w] = '0;
        send_request(OP_LOOKUP, k);
        send_request(OP_LOOKUP, k);
        for (int w = 0; w < 8; w++) k[w] = '1;
        send_request(OP_LOOKUP, k);
        send_request(OP_LOOKUP, k);
        for (int w = 0; w < 8; w++) k[w] = 64'h0123456789ABCDEF ^ w;
        send_request(OP_LOOKUP, k);
        send_clear();
        send_request(OP_LOOKUP, k);
        write_fill_limit(9'd1);
        send_clear();
        send_key_from_pool(0);
        send_key_from_pool(1);
        send_key_from_pool(0);
        send_clear();

        // Random phases across several limits, extremes included.
        idle_allowed = 1;
        foreach (int_limits[j]) begin
            write_fill_limit(int_limits[j]);
            send_clear();
            for (int n = 0; n < 200; n++) begin
                case ($urandom_range(0, 19))
                    0: send_clear();
                    1, 2, 3, 4, 5, 6, 7: send_key_from_pool($urandom_range(0, 15));
                    default: send_random_key();
                endcase
            end
        end
        // Fill the table to the top fill limit of 511, then look up each pool key.
        write_fill_limit(9'd511);
        send_clear();
        for (int n = 0; n < 520; n++) send_random_key();
        idle_allowed = 0;
        for (int p = 0; p < 16; p++) send_key_from_pool(p);

        wait_cycles = 0;
        while (table_model.pending.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (600) @(posedge i_clk);
        if (table_model.errors == 0 && table_model.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
